// ===== rtl/kst_pkg.sv =====
// shared constants and state type for the keyed slot table
`timescale 1ns / 1ps

package kst_pkg;

  // fixed field widths
  localparam int KEY_W   = 32;
  localparam int KIND_W  = 16;
  localparam int POS_W   = 64;
  localparam int FUNC_W  = 2;
  localparam int IDXO_W  = 6;
  localparam int CNTO_W  = 7;

  // default table depth
  localparam int TABLE_SLOTS_DEF = 64;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_UPSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ===== rtl/keyed_slot_table.sv =====
// top level of the keyed slot table: request capture, cell chain, commit and result
`timescale 1ns / 1ps

// keyed slot table with upsert, update and remove
//
// input channel s_*: one operation per transfer; s_tuser carries the
// operation code and the entry kind, s_tdata the key and three coordinates.
// output channel m_*: one result per operation; m_tuser is the success flag,
// m_tdata holds the slot index and the active slot count.
//
// a request enters cell 0 of a chain of TABLE_SLOTS cells and moves one cell
// per cycle, picking up the first matching key and the first free slot.
// the commit happens as the wave leaves the last cell, and the result is then
// registered on its way to m_tvalid. one operation is in flight at a time:
// no new request is taken until the one in flight has committed.
// reset clears all valid marks, the slot count and both channels at once.
// if the receiver stalls, one further result may finish into a skid register;
// besides the request in flight, input is held off only while that register
// is occupied.
module keyed_slot_table #(
  parameter int TABLE_SLOTS = kst_pkg::TABLE_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [223:0] s_tdata,   // key_id[31:0], pos_x, pos_y, pos_z
  input  logic [17:0]  s_tuser,   // func[1:0], entry_kind[17:2]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // slot_index[5:0], active_count[12:6], zero pad
  output logic         m_tuser    // success
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_W = kst_pkg::KEY_W;
  localparam int POS_W = kst_pkg::POS_W;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic             match_hit;
    logic [IDX_W-1:0] match_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
  } wave_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             set_valid;
    logic             clr_valid;
    logic [KEY_W-1:0] key;
  } wr_t;

  // input field unpacking
  logic [kst_pkg::FUNC_W-1:0] in_func;
  logic [KEY_W-1:0]           in_key;
  logic [kst_pkg::KIND_W-1:0] in_kind;
  logic [POS_W-1:0]           in_x, in_y, in_z;

  assign in_func = s_tuser[1:0];
  assign in_kind = s_tuser[17:2];
  assign in_key  = s_tdata[31:0];
  assign in_x    = s_tdata[95:32];
  assign in_y    = s_tdata[159:96];
  assign in_z    = s_tdata[223:160];

  logic s_xfer;
  assign s_xfer = s_tvalid && s_tready;

  // request held while its wave runs down the chain
  logic [kst_pkg::FUNC_W-1:0] req_func;
  logic [kst_pkg::KIND_W-1:0] req_kind;
  logic [POS_W-1:0]           req_x, req_y, req_z;

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      req_func <= in_func;
      req_kind <= in_kind;
      req_x    <= in_x;
      req_y    <= in_y;
      req_z    <= in_z;
    end
  end

  // cell chain
  wave_t wave [TABLE_SLOTS+1];
  wr_t   wr;

  always_comb begin
    wave[0]     = '0;
    wave[0].vld = s_xfer;
    wave[0].key = in_key;
  end

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    kst_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g),
      .wave_t   (wave_t),
      .wr_t     (wr_t)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (wave[g]),
      .wave_out (wave[g+1]),
      .wr       (wr)
    );
  end

  wave_t tail;
  assign tail = wave[TABLE_SLOTS];

  // commit as the wave leaves the last cell
  logic             commit;
  logic             hit;
  logic [IDX_W-1:0] idx_sel;
  logic             wr_kind_y;
  logic             wr_x_z;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign commit = tail.vld;

  always_comb begin
    hit       = 1'b0;
    idx_sel   = '0;
    wr        = '0;
    wr.key    = tail.key;
    wr_kind_y = 1'b0;
    wr_x_z    = 1'b0;
    cnt_next  = cnt;
    unique case (req_func)
      kst_pkg::OP_UPSERT: begin
        if (tail.match_hit) begin
          hit     = 1'b1;
          idx_sel = tail.match_idx;
        end else if (tail.free_hit) begin
          hit      = 1'b1;
          idx_sel  = tail.free_idx;
          cnt_next = cnt + CNT_W'(1);
        end
        wr.set_valid = hit;
        wr_kind_y    = hit;
        wr_x_z       = hit;
      end
      kst_pkg::OP_UPDATE: begin
        hit     = tail.match_hit;
        idx_sel = tail.match_idx;
        wr_x_z  = hit;
      end
      kst_pkg::OP_REMOVE: begin
        hit          = tail.match_hit;
        idx_sel      = tail.match_idx;
        wr.clr_valid = hit;
        if (hit) begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      default: begin
        // unused code: no change, reports failure
      end
    endcase
    wr.en  = commit && hit;
    wr.idx = idx_sel;
    if (!commit) begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // slot payload store, written on upsert and update
  logic [kst_pkg::KIND_W-1:0] mem_kind [TABLE_SLOTS];
  logic [POS_W-1:0]           mem_x    [TABLE_SLOTS];
  logic [POS_W-1:0]           mem_y    [TABLE_SLOTS];
  logic [POS_W-1:0]           mem_z    [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (commit && wr_kind_y) begin
      mem_kind[idx_sel] <= req_kind;
      mem_y[idx_sel]    <= req_y;
    end
    if (commit && wr_x_z) begin
      mem_x[idx_sel] <= req_x;
      mem_z[idx_sel] <= req_z;
    end
  end

  // result word
  logic                       res_success;
  logic [kst_pkg::IDXO_W-1:0] res_idx;
  logic [kst_pkg::CNTO_W-1:0] res_cnt;

  assign res_success = hit;
  assign res_idx     = hit ? kst_pkg::IDXO_W'(idx_sel) : '0;
  assign res_cnt     = kst_pkg::CNTO_W'(cnt_next);

  // output register plus one skid entry
  logic                       out_vld;
  logic                       out_success;
  logic [kst_pkg::IDXO_W-1:0] out_idx;
  logic [kst_pkg::CNTO_W-1:0] out_cnt;
  logic                       skid_vld;
  logic                       skid_success;
  logic [kst_pkg::IDXO_W-1:0] skid_idx;
  logic [kst_pkg::CNTO_W-1:0] skid_cnt;
  logic                       out_free;

  assign out_free = !out_vld || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld <= skid_vld || commit;
      end
      if (skid_vld && out_free) begin
        skid_vld <= 1'b0;
      end else if (commit && !out_free) begin
        skid_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_vld) begin
        out_success <= skid_success;
        out_idx     <= skid_idx;
        out_cnt     <= skid_cnt;
      end else begin
        out_success <= res_success;
        out_idx     <= res_idx;
        out_cnt     <= res_cnt;
      end
    end
    if (commit && !out_free) begin
      skid_success <= res_success;
      skid_idx     <= res_idx;
      skid_cnt     <= res_cnt;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_success;
  assign m_tdata  = {3'b000, out_cnt, out_idx};

  // sequencer
  kst_pkg::state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      kst_pkg::ST_IDLE: begin
        if (s_xfer) begin
          state_next = kst_pkg::ST_SCAN;
        end
      end
      kst_pkg::ST_SCAN: begin
        if (commit) begin
          state_next = kst_pkg::ST_IDLE;
        end
      end
      default: state_next = kst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    s_tready = (state == kst_pkg::ST_IDLE) && !skid_vld;
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_SLOTS))
    else $error("active count above table size");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.vld |-> state == kst_pkg::ST_SCAN)
    else $error("wave left the chain with no request in flight");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid entry held while output register empty");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    commit && req_func == kst_pkg::OP_REMOVE && tail.match_hit
      |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("remove hit did not lower the active count");

endmodule

// ===== rtl/kst_cell.sv =====
// one slot of the table: valid mark, key, and one stage of the lookup wave
`timescale 1ns / 1ps

module kst_cell #(
  parameter int  IDX_W    = 6,
  parameter int  CELL_IDX = 0,
  parameter type wave_t   = logic,
  parameter type wr_t     = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  wave_t wave_in,
  output wave_t wave_out,
  input  wr_t   wr
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                     valid;
  logic [kst_pkg::KEY_W-1:0] key;
  wave_t                    wave_next;

  // fold this slot into the passing wave
  always_comb begin
    wave_next = wave_in;
    if (!wave_in.match_hit && valid && key == wave_in.key) begin
      wave_next.match_hit = 1'b1;
      wave_next.match_idx = MY_IDX;
    end
    if (!wave_in.free_hit && !valid) begin
      wave_next.free_hit = 1'b1;
      wave_next.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.vld <= 1'b0;
    end else begin
      wave_out.vld <= wave_next.vld;
    end
    wave_out.key       <= wave_next.key;
    wave_out.match_hit <= wave_next.match_hit;
    wave_out.match_idx <= wave_next.match_idx;
    wave_out.free_hit  <= wave_next.free_hit;
    wave_out.free_idx  <= wave_next.free_idx;
  end

  // write-back addressed to this slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr.idx == MY_IDX) begin
      if (wr.set_valid) begin
        valid <= 1'b1;
      end else if (wr.clr_valid) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == MY_IDX && wr.set_valid) begin
      key <= wr.key;
    end
  end

endmodule

// ===== test/tb_keyed_slot_table.sv =====
// self-checking testbench for the keyed slot table
`timescale 1ns / 1ps

module tb_keyed_slot_table;
  import kst_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  // code outside the three defined operations, must be a no-op
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;
  // cycles with no transfer on either side before the run is abandoned;
  // the chain, result stalls and input gaps all add to a quiet stretch
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1200;

  // traffic shapes for the random part
  typedef enum int {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } workload_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;   // key_id, pos_x, pos_y, pos_z
  logic [17:0]  s_tuser;   // func, entry_kind
  logic         m_tvalid;
  logic         m_tready;
  logic [15:0]  m_tdata;   // slot_index, active_count, zero pad
  logic         m_tuser;   // success

  // idle gaps on both sides are on unless a stretch turns them off
  bit idling = 1'b1;
  int unsigned quiet_cycles;

  keyed_slot_table #(.TABLE_SLOTS(SLOTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // mirror of the slot table; turns each accepted operation into the
  // result it must produce and checks results in order
  class slot_table_tracker;
    typedef struct {
      bit                ok;
      bit [IDXO_W-1:0]   slot;
      bit [CNTO_W-1:0]   count;
    } slot_result_t;

    bit              valid [SLOTS];
    bit [KEY_W-1:0]  key   [SLOTS];
    bit [KIND_W-1:0] kind  [SLOTS];
    bit [POS_W-1:0]  px    [SLOTS];
    bit [POS_W-1:0]  py    [SLOTS];
    bit [POS_W-1:0]  pz    [SLOTS];
    slot_result_t    awaited_results [$];
    int unsigned     errors;

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void note_request(bit [FUNC_W-1:0] op, bit [KEY_W-1:0] k,
                               bit [KIND_W-1:0] kd, bit [POS_W-1:0] x,
                               bit [POS_W-1:0] y, bit [POS_W-1:0] z);
      int hit;
      int hole;
      int slot;
      int n;
      slot_result_t r;
      hit  = -1;
      hole = -1;
      slot = -1;
      n    = 0;
      // lowest valid slot with the key, lowest free slot
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (valid[i] && key[i] == k) hit = i;
        if (!valid[i]) hole = i;
      end
      case (op)
        OP_UPSERT: begin
          slot = (hit >= 0) ? hit : hole;
          if (slot >= 0) begin
            valid[slot] = 1'b1;
            key[slot]   = k;
            kind[slot]  = kd;
            px[slot]    = x;
            py[slot]    = y;
            pz[slot]    = z;
          end
        end
        OP_UPDATE: begin
          slot = hit;
          if (slot >= 0) begin
            px[slot] = x;
            pz[slot] = z;
          end
        end
        OP_REMOVE: begin
          slot = hit;
          if (slot >= 0) valid[slot] = 1'b0;
        end
        default: slot = -1;
      endcase
      foreach (valid[i]) n += valid[i];
      r.ok    = (slot >= 0);
      r.slot  = (slot >= 0) ? slot[IDXO_W-1:0] : '0;
      r.count = n[CNTO_W-1:0];
      awaited_results.push_back(r);
    endfunction

    function void check_result(bit ok, bit [IDXO_W-1:0] slot, bit [CNTO_W-1:0] count);
      slot_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (ok != want.ok) begin
        $error("success: expected %0d, got %0d", want.ok, ok);
        errors++;
      end
      if (slot != want.slot) begin
        $error("slot_index: expected %0d, got %0d", want.slot, slot);
        errors++;
      end
      if (count != want.count) begin
        $error("active_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  slot_table_tracker tracker;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor: compare results, record accepted operations, watch for hangs
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) tracker.check_result(m_tuser, m_tdata[5:0], m_tdata[12:6]);
      if (s_tvalid && s_tready)
        tracker.note_request(s_tuser[1:0], s_tdata[31:0], s_tuser[17:2],
                             s_tdata[95:32], s_tdata[159:96], s_tdata[223:160]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT - 1) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random stalls, sometimes held until a result is waiting
  initial begin
    int unsigned stall;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = idling ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!m_tvalid);
        end
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // one operation transfer; valid stays up into the next call when it has no gap
  task automatic send_op(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
                         logic [KIND_W-1:0] kd, logic [POS_W-1:0] x,
                         logic [POS_W-1:0] y, logic [POS_W-1:0] z);
    int unsigned gap;
    gap = idling ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x, k};
    s_tuser  <= {kd, op};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [FUNC_W-1:0] pick_op(workload_t mix);
    int unsigned roll;
    int unsigned up_lim;
    int unsigned upd_lim;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin up_lim = 85; upd_lim = 95; end
      MIX_CHURN: begin up_lim = 45; upd_lim = 70; end
      default:   begin up_lim = 15; upd_lim = 30; end
    endcase
    if (roll < 3) return OP_UNUSED;
    if (roll < up_lim) return OP_UPSERT;
    if (roll < upd_lim) return OP_UPDATE;
    return OP_REMOVE;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int unsigned          sent;
    int unsigned          run_len;
    int unsigned          pool_n;
    logic [KEY_W-1:0]     key_base;
    logic [KEY_W-1:0]     k;
    logic [FUNC_W-1:0]    op;
    workload_t            mix;
    bit                   paused;
    tracker  = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table misses, unused code, key extremes, in-place
    // rewrite, update hit and miss, remove and reuse of the freed slot
    send_op(OP_UPDATE, 32'h0, 16'h0, '0, '0, '0);
    send_op(OP_REMOVE, 32'h0, 16'h0, '0, '0, '0);
    send_op(OP_UNUSED, 32'h0, 16'h0, '0, '0, '0);
    send_op(OP_UPSERT, 32'h7fff_ffff, 16'hffff, '1, '1, '1);
    send_op(OP_UPSERT, 32'h8000_0000, 16'h0, '0, '0, '0);
    send_op(OP_UPSERT, 32'h0, 16'h5a5a, rand_pos(), rand_pos(), rand_pos());
    send_op(OP_UPSERT, 32'hffff_ffff, 16'ha5a5, rand_pos(), rand_pos(), rand_pos());
    send_op(OP_UPSERT, 32'h7fff_ffff, 16'h0001, '0, '1, '0);
    send_op(OP_UPDATE, 32'h8000_0000, 16'hffff, '1, '0, '1);
    send_op(OP_UPDATE, 32'h0001_2345, 16'h0, rand_pos(), rand_pos(), rand_pos());
    send_op(OP_REMOVE, 32'h0, 16'h0, '0, '0, '0);
    send_op(OP_REMOVE, 32'h0, 16'h0, '0, '0, '0);
    send_op(OP_UPSERT, 32'h0000_0005, 16'h1234, rand_pos(), rand_pos(), rand_pos());
    send_op(OP_UNUSED, 32'hffff_ffff, 16'hffff, '1, '1, '1);
    send_op(OP_REMOVE, 32'hffff_ffff, 16'h0, '0, '0, '0);
    send_op(OP_UPSERT, 32'hffff_fffe, 16'h8000, rand_pos(), rand_pos(), rand_pos());
    drain_results();

    // random: runs over a key pool so that keys repeat; fill runs use more
    // keys than slots, which drives the table full and into failed upserts
    sent     = 0;
    paused   = 1'b0;
    key_base = $urandom();
    while (sent < RANDOM_ITEMS) begin
      mix = workload_t'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) key_base = $urandom();
      pool_n  = (mix == MIX_FILL) ? $urandom_range(66, 100) : $urandom_range(4, 40);
      run_len = (mix == MIX_FILL) ? $urandom_range(150, 200) : $urandom_range(30, 100);
      idling  = ($urandom_range(0, 3) != 0);
      repeat (run_len) begin
        if (sent >= RANDOM_ITEMS) break;
        op = pick_op(mix);
        if ($urandom_range(0, 19) == 0) k = $urandom();
        else k = key_base + $urandom_range(0, pool_n - 1);
        send_op(op, k, KIND_W'($urandom()), rand_pos(), rand_pos(), rand_pos());
        sent++;
      end
      if (!paused || $urandom_range(0, 3) == 0) begin
        drain_results();
        paused = 1'b1;
      end
    end

    // let the last results through, then stay quiet before the verdict
    drain_results();
    repeat (SLOTS + 10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
